>>> hdl/tcpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpc_pkg - shared definitions for the text console
// Field widths, control codes, register indexes and the cursor types passed
// between the sequencer and the cursor step logic.
// ----------------------------------------------------------------------------
package tcpc_pkg;

    // field widths
    localparam int COL_W   = 8;
    localparam int ROW_W   = 7;
    localparam int CHR_W   = 8;
    localparam int ATTR_W  = 8;
    localparam int CELL_W  = 16;
    localparam int LOC_W   = 11;
    localparam int RADDR_W = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;
    // widest product of the multiply-add unit: 127 * 255 + 255
    localparam int PROD_W  = 15;
    // working width for cell indexes before they are range-checked
    localparam int ADR_W   = 16;

    // operations
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR = 2'd2;

    // register reset values
    localparam logic [COL_W-1:0]  COLUMNS_RESET = 8'd80;
    localparam logic [ROW_W-1:0]  ROWS_RESET    = 7'd25;
    localparam logic [ATTR_W-1:0] COLOR_RESET   = 8'd7;

    // character codes
    localparam logic [CHR_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [CHR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHR_W-1:0] CHAR_SPACE = 8'h20;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } cursor_t;

    typedef struct packed {
        cursor_t pos;
        logic    printable;
    } step_t;

endpackage

>>> hdl/tcpc_cursor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpc_cursor - cursor step for one put-character transfer
// Interprets control codes, advances the cursor after a printable code and
// wraps at the end of the line. The row may land one past the screen; the
// sequencer scrolls in that case.
// ----------------------------------------------------------------------------
module tcpc_cursor #(
    parameter int TAB_WIDTH = 8
) (
    input  tcpc_pkg::cursor_t           cur,
    input  logic [tcpc_pkg::CHR_W-1:0]  character,
    input  logic [tcpc_pkg::COL_W-1:0]  columns,
    output tcpc_pkg::step_t             step_out
);
    import tcpc_pkg::*;

    localparam int REM_W = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
    localparam int X_W   = COL_W + 1;

    logic [REM_W-1:0] tab_rem [2**COL_W];
    logic [X_W-1:0]   x_next;
    logic [ROW_W-1:0] y_next;
    logic             printable;

    // build the column remainder table at elaboration
    genvar g;
    for (g = 0; g < 2**COL_W; g = g + 1) begin : g_tab
        assign tab_rem[g] = REM_W'(g % TAB_WIDTH);
    end

    // decode the code, then wrap at the end of the line
    always_comb
    begin
        x_next    = {1'b0, cur.col};
        y_next    = cur.row;
        printable = 1'b0;
        if (character == CHAR_BS && cur.col != '0)
        begin
            x_next = {1'b0, cur.col} - X_W'(1);
        end
        else if (character == CHAR_TAB)
        begin
            x_next = {1'b0, cur.col} + X_W'(TAB_WIDTH) - X_W'(tab_rem[cur.col]);
        end
        else if (character == CHAR_CR)
        begin
            x_next = '0;
        end
        else if (character == CHAR_LF)
        begin
            x_next = '0;
            y_next = cur.row + ROW_W'(1);
        end
        else if (character >= CHAR_SPACE)
        begin
            printable = 1'b1;
            x_next    = {1'b0, cur.col} + X_W'(1);
        end

        if (x_next >= {1'b0, columns})
        begin
            x_next = '0;
            y_next = y_next + ROW_W'(1);
        end

        step_out.pos.col   = x_next[COL_W-1:0];
        step_out.pos.row   = y_next;
        step_out.printable = printable;
    end

endmodule

>>> hdl/tcpc_muladd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpc_muladd - shared multiply-add unit
// Registered a * b + c, used for cell addresses, the cursor location and the
// scroll extent.
// ----------------------------------------------------------------------------
module tcpc_muladd (
    input  logic                         clk,
    input  logic [tcpc_pkg::ROW_W-1:0]   mul_a,
    input  logic [tcpc_pkg::COL_W-1:0]   mul_b,
    input  logic [tcpc_pkg::COL_W-1:0]   add_c,
    output logic [tcpc_pkg::PROD_W-1:0]  result
);
    import tcpc_pkg::*;

    logic [PROD_W-1:0] result_reg;
    logic [PROD_W-1:0] result_next;

    // form the product and sum
    assign result_next = PROD_W'(mul_a) * PROD_W'(mul_b) + PROD_W'(add_c);

    // hold the result for the next step of the sequencer
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

>>> hdl/text_console_put_character.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_put_character - text-mode console with cell buffer and cursor
// Puts characters at the cursor, interprets control codes, scrolls, and
// reads cells back for display refresh.
// ----------------------------------------------------------------------------
// After reset the block clears its buffer, one cell per cycle, and takes no
// transfer before the clear ends; configuration writes are taken at any time.
// A read passes through the read and output steps and a put through the
// calculate, write and output steps, set by the registered buffer read and
// the shared multiply-add unit that forms the cell address and then the
// cursor location. A put that scrolls also runs the scroll loop: the buffer
// is copied up one line and the last line blanked at one cell per cycle
// through the buffer's write port. The result waits in an output register;
// a new transfer is accepted once the previous one has left the sequencer.
// ----------------------------------------------------------------------------
module text_console_put_character #(
    parameter int CELLS     = 2048,
    parameter int TAB_WIDTH = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             operation,
    input  logic [tcpc_pkg::CHR_W-1:0]       character,
    input  logic [tcpc_pkg::RADDR_W-1:0]     read_address,
    // result channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [tcpc_pkg::LOC_W-1:0]       cursor_location,
    output logic [tcpc_pkg::CELL_W-1:0]      cell_data,
    // configuration channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tcpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcpc_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import tcpc_pkg::*;

    localparam int AW = $clog2(CELLS);
    localparam int IW = $clog2(CELLS + 1);
    localparam logic [ADR_W-1:0] CELLS_W = ADR_W'(CELLS);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_CALC   = 3'd2;
    localparam logic [2:0] ST_WRITE  = 3'd3;
    localparam logic [2:0] ST_SETUP  = 3'd4;
    localparam logic [2:0] ST_SCROLL = 3'd5;
    localparam logic [2:0] ST_READ   = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    // control state
    logic [2:0]        state_reg, state_next;
    logic [COL_W-1:0]  columns_reg;
    logic [ROW_W-1:0]  rows_reg;
    logic [ATTR_W-1:0] color_reg;
    cursor_t           cur_reg, cur_next;
    logic [AW-1:0]     clr_idx_reg, clr_idx_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic              stage_valid_reg, stage_valid_next;
    logic              out_valid_reg, out_valid_next;

    // payload
    logic [CHR_W-1:0]  ch_reg, ch_next;
    logic              printable_reg, printable_next;
    logic              rd_zero_reg, rd_zero_next;
    logic [CELL_W-1:0] cell_reg, cell_next;
    logic [PROD_W-1:0] keep_reg, keep_next;
    logic [PROD_W-1:0] total_reg, total_next;
    logic [AW-1:0]     stage_addr_reg, stage_addr_next;
    logic              stage_mem_reg, stage_mem_next;
    logic              stage_zero_reg, stage_zero_next;
    logic [LOC_W-1:0]  out_loc_reg, out_loc_next;
    logic [CELL_W-1:0] out_data_reg, out_data_next;

    // buffer
    logic [CELL_W-1:0] text_buffer [CELLS];
    logic [CELL_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    // shared unit and helpers
    logic [ROW_W-1:0]  mul_a;
    logic [COL_W-1:0]  mul_b;
    logic [COL_W-1:0]  mul_c;
    logic [PROD_W-1:0] prod;
    step_t             step;
    logic [COL_W-1:0]  eff_cols;
    logic [ROW_W-1:0]  eff_rows;
    logic [ROW_W-1:0]  last_row;
    logic [CELL_W-1:0] blank;
    logic [ADR_W-1:0]  idx_ext;
    logic [ADR_W-1:0]  src_addr;
    logic [ADR_W-1:0]  rd_addr_ext;

    // zero geometry acts as one
    assign eff_cols    = (columns_reg == '0) ? COL_W'(1) : columns_reg;
    assign eff_rows    = (rows_reg == '0) ? ROW_W'(1) : rows_reg;
    assign last_row    = eff_rows - ROW_W'(1);
    assign blank       = {color_reg, CHAR_SPACE};
    assign idx_ext     = ADR_W'(idx_reg);
    assign src_addr    = idx_ext + ADR_W'(eff_cols);
    assign rd_addr_ext = ADR_W'(read_address);

    tcpc_cursor #(
        .TAB_WIDTH (TAB_WIDTH)
    ) u_cursor (
        .cur       (cur_reg),
        .character (ch_reg),
        .columns   (eff_cols),
        .step_out  (step)
    );

    tcpc_muladd u_muladd (
        .clk    (clk),
        .mul_a  (mul_a),
        .mul_b  (mul_b),
        .add_c  (mul_c),
        .result (prod)
    );

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        cur_next         = cur_reg;
        clr_idx_next     = clr_idx_reg;
        idx_next         = idx_reg;
        stage_valid_next = 1'b0;
        out_valid_next   = out_valid_reg & out_stall;
        ch_next          = ch_reg;
        printable_next   = printable_reg;
        rd_zero_next     = rd_zero_reg;
        cell_next        = cell_reg;
        keep_next        = keep_reg;
        total_next       = total_reg;
        stage_addr_next  = stage_addr_reg;
        stage_mem_next   = stage_mem_reg;
        stage_zero_next  = stage_zero_reg;
        out_loc_next     = out_loc_reg;
        out_data_next    = out_data_reg;
        // the unit tracks the cursor location unless told otherwise
        mul_a            = cur_reg.row;
        mul_b            = eff_cols;
        mul_c            = cur_reg.col;
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = '0;
        mem_re           = 1'b0;
        mem_raddr        = '0;

        // retire the scroll stage: copied cell or blank
        if (stage_valid_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = stage_addr_reg;
            if (stage_mem_reg)
            begin
                mem_wdata = stage_zero_reg ? '0 : rd_data_reg;
            end
            else
            begin
                mem_wdata = blank;
            end
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_idx_reg;
                mem_wdata = '0;
                if (clr_idx_reg == AW'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ch_next = character;
                    if (operation == OP_READ)
                    begin
                        mem_re       = 1'b1;
                        mem_raddr    = rd_addr_ext[AW-1:0];
                        rd_zero_next = (rd_addr_ext >= CELLS_W);
                        state_next   = ST_READ;
                    end
                    else
                    begin
                        cell_next  = '0;
                        state_next = ST_CALC;
                    end
                end
            end
            ST_CALC:
            begin
                // the unit forms the write address from the old cursor
                cur_next       = step.pos;
                printable_next = step.printable;
                state_next     = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (printable_reg && ADR_W'(prod) < CELLS_W)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = prod[AW-1:0];
                    mem_wdata = {color_reg, ch_reg};
                end
                if (cur_reg.row >= eff_rows)
                begin
                    mul_a      = last_row;
                    mul_c      = '0;
                    state_next = ST_SETUP;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_SETUP:
            begin
                keep_next    = prod;
                total_next   = prod + PROD_W'(eff_cols);
                idx_next     = '0;
                cur_next.row = last_row;
                state_next   = ST_SCROLL;
            end
            ST_SCROLL:
            begin
                if (idx_ext >= ADR_W'(total_reg) || idx_reg == IW'(CELLS))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    stage_valid_next = 1'b1;
                    stage_addr_next  = idx_reg[AW-1:0];
                    idx_next         = idx_reg + IW'(1);
                    if (idx_ext < ADR_W'(keep_reg))
                    begin
                        mem_re          = 1'b1;
                        mem_raddr       = src_addr[AW-1:0];
                        stage_mem_next  = 1'b1;
                        stage_zero_next = (src_addr >= CELLS_W);
                    end
                    else
                    begin
                        stage_mem_next  = 1'b0;
                        stage_zero_next = 1'b0;
                    end
                end
            end
            ST_READ:
            begin
                cell_next  = rd_zero_reg ? '0 : rd_data_reg;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_loc_next   = prod[LOC_W-1:0];
                    out_data_next  = cell_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            cur_reg         <= '0;
            clr_idx_reg     <= '0;
            idx_reg         <= '0;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cur_reg         <= cur_next;
            clr_idx_reg     <= clr_idx_next;
            idx_reg         <= idx_next;
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= COLUMNS_RESET;
            rows_reg    <= ROWS_RESET;
            color_reg   <= COLOR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_COLUMNS:    columns_reg <= cfg_data;
                CFG_ROWS:       rows_reg    <= cfg_data[ROW_W-1:0];
                CFG_TEXT_COLOR: color_reg   <= cfg_data;
                default:        columns_reg <= columns_reg;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ch_reg         <= ch_next;
        printable_reg  <= printable_next;
        rd_zero_reg    <= rd_zero_next;
        cell_reg       <= cell_next;
        keep_reg       <= keep_next;
        total_reg      <= total_next;
        stage_addr_reg <= stage_addr_next;
        stage_mem_reg  <= stage_mem_next;
        stage_zero_reg <= stage_zero_next;
        out_loc_reg    <= out_loc_next;
        out_data_reg   <= out_data_next;
    end

    // cell buffer: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            text_buffer[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= text_buffer[mem_raddr];
        end
    end

    assign in_stall        = (state_reg != ST_IDLE);
    assign cfg_ready       = 1'b1;
    assign out_valid       = out_valid_reg;
    assign cursor_location = out_loc_reg;
    assign cell_data       = out_data_reg;

    // an accepted transfer occupies the sequencer on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("sequencer free right after a transfer was accepted");

    // scroll stage writes only happen inside the scroll loop
    a_stage_window: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg |-> (state_reg == ST_SCROLL))
        else $error("scroll stage pending outside the scroll loop");

    // a row one past every possible screen is always scrolled away
    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (cur_reg.row != {ROW_W{1'b1}}))
        else $error("cursor row left past the screen");

    // a result appears only from the output step
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output step");

endmodule
